// ===== src/pvmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvmc_pkg: shared types and constants for the pressure valve motor controller
// Beat payload structs, register map, position and band codes, thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package pvmc_pkg;

  // ADC sample width
  localparam int SAMPLE_BITS = 10;
  // signed working width for setpoint-relative compares
  localparam int CMP_W       = SAMPLE_BITS + 2;

  // counter widths
  localparam int OC_W    = 13;
  localparam int TRAV_W  = 18;
  localparam int PULSE_W = 13;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_OC_LEVEL = 3'd1;
  localparam logic [2:0] REG_OC_TICKS = 3'd2;
  localparam logic [2:0] REG_TRAVEL   = 3'd3;
  localparam logic [2:0] REG_PERIOD   = 3'd4;

  // register reset values
  localparam logic [SAMPLE_BITS-1:0] SETPOINT_RST = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] OC_LEVEL_RST = SAMPLE_BITS'(200);
  localparam logic [OC_W-1:0]        OC_TICKS_RST = OC_W'(5000);
  localparam logic [TRAV_W-1:0]      TRAVEL_RST   = TRAV_W'(150000);
  localparam logic [PULSE_W-1:0]     PERIOD_RST   = PULSE_W'(5000);

  // PWM off points
  localparam logic [PULSE_W-1:0] OFF_RST  = PULSE_W'(4950);
  localparam logic [PULSE_W-1:0] OFF_NEAR = PULSE_W'(4850);
  localparam logic [PULSE_W-1:0] OFF_FAR  = PULSE_W'(4500);

  // limit switch thresholds
  localparam logic [CMP_W-1:0] SW_AZERO_BELOW = CMP_W'(200);
  localparam logic [CMP_W-1:0] SW_ACT_ABOVE   = CMP_W'(400);
  localparam logic [CMP_W-1:0] SW_ACT_BELOW   = CMP_W'(550);
  localparam logic [CMP_W-1:0] SW_OPEN_ABOVE  = CMP_W'(580);
  localparam logic [CMP_W-1:0] SW_OPEN_MAX    = CMP_W'(800);

  // valve positions
  localparam logic [2:0] POS_NONE  = 3'd0;
  localparam logic [2:0] POS_CLOSE = 3'd1;
  localparam logic [2:0] POS_ACT   = 3'd2;
  localparam logic [2:0] POS_OPEN  = 3'd3;
  localparam logic [2:0] POS_AZERO = 3'd5;

  // pressure bands
  localparam logic [2:0] B_UNSET   = 3'd0;
  localparam logic [2:0] B_NONE    = 3'd1;
  localparam logic [2:0] B_LOW     = 3'd2;
  localparam logic [2:0] B_LOWPWM  = 3'd3;
  localparam logic [2:0] B_MID     = 3'd4;
  localparam logic [2:0] B_HIGHPWM = 3'd5;
  localparam logic [2:0] B_HIGH    = 3'd6;

  // system modes
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // timer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pressure;
    logic [SAMPLE_BITS-1:0] switch_level;
    logic [SAMPLE_BITS-1:0] current_level;
    logic [1:0]             sys_mode;
  } in_t;

  typedef struct packed {
    logic       drive_one;
    logic       drive_two;
    logic       confirm_pin;
    logic       auto_zero_request;
    logic [2:0] band;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] setpoint;
    logic [SAMPLE_BITS-1:0] oc_level;
    logic [OC_W-1:0]        oc_ticks;
    logic [TRAV_W-1:0]      travel_ticks;
    logic [PULSE_W-1:0]     period;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/pvmc_cfg.sv =====
// ----------------------------------------------------------------------------
// pvmc_cfg: configuration register file
// APB-style write and read of the five controller registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pvmc_cfg
  import pvmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint     <= SETPOINT_RST;
      cfg_r.oc_level     <= OC_LEVEL_RST;
      cfg_r.oc_ticks     <= OC_TICKS_RST;
      cfg_r.travel_ticks <= TRAVEL_RST;
      cfg_r.period       <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETPOINT: cfg_r.setpoint     <= pwdata[SAMPLE_BITS-1:0];
        REG_OC_LEVEL: cfg_r.oc_level     <= pwdata[SAMPLE_BITS-1:0];
        REG_OC_TICKS: cfg_r.oc_ticks     <= pwdata[OC_W-1:0];
        REG_TRAVEL:   cfg_r.travel_ticks <= pwdata[TRAV_W-1:0];
        REG_PERIOD:   cfg_r.period       <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_SETPOINT: prdata = DATA_W'(cfg_r.setpoint);
      REG_OC_LEVEL: prdata = DATA_W'(cfg_r.oc_level);
      REG_OC_TICKS: prdata = DATA_W'(cfg_r.oc_ticks);
      REG_TRAVEL:   prdata = DATA_W'(cfg_r.travel_ticks);
      REG_PERIOD:   prdata = DATA_W'(cfg_r.period);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pvmc_core.sv =====
// ----------------------------------------------------------------------------
// pvmc_core: per-tick controller state and update logic
// Limit switch confirm, band classification, stop latches, timers and PWM.
// ----------------------------------------------------------------------------
`default_nettype none

module pvmc_core
  import pvmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      result
);

  logic [2:0]         conf_r, conf_nxt, cand_r, cand_nxt;
  logic [2:0]         band_r, band_nxt, before_r, before_nxt;
  logic               cstop_r, cstop_nxt, ostop_r, ostop_nxt;
  logic [1:0]         ocph_r, ocph_nxt, trph_r, trph_nxt;
  logic [OC_W-1:0]    occnt_r, occnt_nxt;
  logic [TRAV_W-1:0]  trcnt_r, trcnt_nxt;
  logic               pen_r, pen_nxt;
  logic [PULSE_W-1:0] pcnt_r, pcnt_nxt, poff_r, poff_nxt;
  logic               d1_r, d1_nxt, d2_r, d2_nxt, conf_pin_r, conf_pin_nxt;

  logic [2:0]              cls;
  logic [CMP_W-1:0]        swx;
  logic signed [CMP_W-1:0] ps, ss, s_m5, s_m6, s_p5, s_p6;

  assign swx  = CMP_W'(item.switch_level);
  assign ps   = signed'(CMP_W'(item.pressure));
  assign ss   = signed'(CMP_W'(cfg.setpoint));
  assign s_m5 = ss - CMP_W'(5);
  assign s_m6 = ss - CMP_W'(6);
  assign s_p5 = ss + CMP_W'(5);
  assign s_p6 = ss + CMP_W'(6);

  // classify limit switch level; gaps leave position unchanged
  always_comb begin
    priority if (swx > SW_ACT_ABOVE && swx < SW_ACT_BELOW) cls = POS_ACT;
    else if (swx > SW_OPEN_ABOVE && swx <= SW_OPEN_MAX)     cls = POS_OPEN;
    else if (swx > SW_OPEN_MAX)                             cls = POS_CLOSE;
    else if (swx < SW_AZERO_BELOW)                          cls = POS_AZERO;
    else                                                    cls = POS_NONE;
  end

  // one tick of the control sequence, in program order
  always_comb begin
    conf_nxt     = conf_r;
    cand_nxt     = cand_r;
    band_nxt     = band_r;
    before_nxt   = before_r;
    cstop_nxt    = cstop_r;
    ostop_nxt    = ostop_r;
    ocph_nxt     = ocph_r;
    occnt_nxt    = occnt_r;
    trph_nxt     = trph_r;
    trcnt_nxt    = trcnt_r;
    pen_nxt      = pen_r;
    pcnt_nxt     = pcnt_r;
    poff_nxt     = poff_r;
    d1_nxt       = d1_r;
    d2_nxt       = d2_r;
    conf_pin_nxt = conf_pin_r;

    // confirm position over two agreeing ticks
    if (cls != POS_NONE) begin
      if (cand_r == cls) conf_nxt = cls;
      cand_nxt = cls;
    end

    // band with one-count hysteresis
    if (item.sys_mode == MODE_RUN) begin
      priority if (ps < s_m5) begin
        if (!(band_r == B_LOWPWM && ps == s_m6)) band_nxt = B_LOW;
      end else if (ps < ss) begin
        band_nxt = B_LOWPWM;
      end else if (ps == ss) begin
        band_nxt = B_MID;
      end else if (ps < s_p5) begin
        band_nxt = B_HIGHPWM;
      end else if (ps > s_p5) begin
        if (!(band_r == B_HIGHPWM && ps == s_p6)) band_nxt = B_HIGH;
      end else begin
        // setpoint plus five keeps the band
        band_nxt = band_r;
      end
    end else if (item.sys_mode == MODE_STOP) begin
      band_nxt = B_NONE;
    end

    // band change: clear timers, set or clear stop latches, start travel timer
    if (band_nxt != before_r) begin
      pcnt_nxt  = '0;
      pen_nxt   = 1'b0;
      trph_nxt  = PH_IDLE;
      trcnt_nxt = '0;
      ocph_nxt  = PH_IDLE;
      occnt_nxt = '0;
      unique case (band_nxt)
        B_NONE, B_HIGH: begin
          if (before_r == B_HIGHPWM && conf_nxt == POS_CLOSE) cstop_nxt = 1'b1;
          else begin
            trph_nxt  = PH_RUN;
            ostop_nxt = 1'b0;
          end
        end
        B_LOW: begin
          if (before_r == B_LOWPWM && conf_nxt == POS_OPEN) ostop_nxt = 1'b1;
          else begin
            trph_nxt  = PH_RUN;
            cstop_nxt = 1'b0;
          end
        end
        B_LOWPWM:  cstop_nxt = 1'b0;
        B_HIGHPWM: ostop_nxt = 1'b0;
        default: ;
      endcase
      before_nxt = band_nxt;
    end

    // drive from band
    unique case (band_nxt)
      B_NONE, B_HIGH:      d2_nxt = !cstop_nxt;
      B_LOW:               d1_nxt = !ostop_nxt;
      B_LOWPWM, B_HIGHPWM: pen_nxt = 1'b1;
      default: begin
        d1_nxt = 1'b0;
        d2_nxt = 1'b0;
      end
    endcase

    // sample overcurrent
    if (item.current_level > cfg.oc_level) ocph_nxt = PH_RUN;
    else begin
      ocph_nxt  = PH_IDLE;
      occnt_nxt = '0;
    end

    // overcurrent timer
    if (ocph_nxt == PH_RUN) begin
      occnt_nxt = occnt_nxt + OC_W'(1);
      if (occnt_nxt == cfg.oc_ticks) begin
        d1_nxt    = 1'b0;
        d2_nxt    = 1'b0;
        pcnt_nxt  = '0;
        pen_nxt   = 1'b0;
        trph_nxt  = PH_IDLE;
        trcnt_nxt = '0;
        ocph_nxt  = PH_IDLE;
        occnt_nxt = '0;
        if (band_nxt == B_NONE) begin
          cstop_nxt    = 1'b1;
          conf_pin_nxt = 1'b0;
        end else if (band_nxt == B_LOW) begin
          ostop_nxt    = 1'b1;
          conf_pin_nxt = 1'b1;
        end else if (band_nxt == B_HIGH) begin
          cstop_nxt = 1'b1;
        end
      end
    end
    if (band_nxt == B_HIGH) conf_pin_nxt = 1'b1;

    // travel timeout timer
    if (trph_nxt == PH_RUN) begin
      trcnt_nxt = trcnt_nxt + TRAV_W'(1);
      if (trcnt_nxt < cfg.travel_ticks) begin
        if (band_nxt == B_NONE || band_nxt == B_HIGH) begin
          if (conf_nxt == POS_CLOSE) cstop_nxt = 1'b1;
          if (conf_nxt == POS_ACT)   cstop_nxt = 1'b0;
        end else if (band_nxt == B_LOW) begin
          if (conf_nxt == POS_OPEN) begin
            ostop_nxt    = 1'b1;
            conf_pin_nxt = 1'b1;
          end
          if (conf_nxt == POS_ACT) ostop_nxt = 1'b0;
        end
      end else begin
        trcnt_nxt = '0;
        trph_nxt  = PH_DONE;
        if (band_nxt == B_NONE || band_nxt == B_HIGH) cstop_nxt = 1'b1;
        else if (band_nxt == B_LOW)                   ostop_nxt = 1'b1;
        if (band_nxt == B_NONE) conf_pin_nxt = 1'b0;
      end
    end

    if (item.sys_mode == MODE_STOP && conf_nxt == POS_CLOSE) conf_pin_nxt = 1'b0;

    // slow PWM in the bands next to the setpoint
    if (pen_nxt) begin
      if (band_nxt == B_LOWPWM)       poff_nxt = (ps > s_m6) ? OFF_NEAR : OFF_FAR;
      else if (band_nxt == B_HIGHPWM) poff_nxt = (ps < s_p6) ? OFF_NEAR : OFF_FAR;
      pcnt_nxt = pcnt_nxt + PULSE_W'(1);
      if (pcnt_nxt < poff_nxt) begin
        d1_nxt = 1'b0;
        d2_nxt = 1'b0;
      end else if (pcnt_nxt < cfg.period) begin
        if (band_nxt == B_LOWPWM) begin
          if (!ostop_nxt) begin
            if (conf_nxt == POS_OPEN) begin
              conf_pin_nxt = 1'b1;
              d1_nxt       = 1'b0;
            end else begin
              d1_nxt = 1'b1;
            end
          end else begin
            d1_nxt = 1'b0;
          end
        end else if (band_nxt == B_HIGHPWM) begin
          d2_nxt = !cstop_nxt && conf_nxt != POS_CLOSE;
        end
      end
      if (pcnt_nxt >= cfg.period) pcnt_nxt = '0;
    end
  end

  assign result.drive_one         = d1_nxt;
  assign result.drive_two         = d2_nxt;
  assign result.confirm_pin       = conf_pin_nxt;
  assign result.auto_zero_request = (conf_nxt == POS_AZERO);
  assign result.band              = band_nxt;

  // commit state on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_r     <= POS_NONE;
      cand_r     <= POS_NONE;
      band_r     <= B_UNSET;
      before_r   <= B_UNSET;
      cstop_r    <= 1'b0;
      ostop_r    <= 1'b0;
      ocph_r     <= PH_IDLE;
      occnt_r    <= '0;
      trph_r     <= PH_IDLE;
      trcnt_r    <= '0;
      pen_r      <= 1'b0;
      pcnt_r     <= '0;
      poff_r     <= OFF_RST;
      d1_r       <= 1'b0;
      d2_r       <= 1'b0;
      conf_pin_r <= 1'b0;
    end else if (step) begin
      conf_r     <= conf_nxt;
      cand_r     <= cand_nxt;
      band_r     <= band_nxt;
      before_r   <= before_nxt;
      cstop_r    <= cstop_nxt;
      ostop_r    <= ostop_nxt;
      ocph_r     <= ocph_nxt;
      occnt_r    <= occnt_nxt;
      trph_r     <= trph_nxt;
      trcnt_r    <= trcnt_nxt;
      pen_r      <= pen_nxt;
      pcnt_r     <= pcnt_nxt;
      poff_r     <= poff_nxt;
      d1_r       <= d1_nxt;
      d2_r       <= d2_nxt;
      conf_pin_r <= conf_pin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/pressure_valve_motor_controller.sv =====
// A beat passes the input register and core, then the result register.
// Throughput: 1 tick per cycle; the input register and result register
// let a new beat enter every cycle while the output is taken.
// The per-tick state update is one combinational pass in pvmc_core.
// Reset (rst_n low, synchronous) empties both registers, clears the
// controller state and restores the configuration register defaults.
// ----------------------------------------------------------------------------
// pressure_valve_motor_controller: valve motor drive from pressure ticks
// Input register, single-pass controller core, result register, APB config.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_valve_motor_controller
  import pvmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  in_t  stage_r;
  logic stage_v_r;
  out_t out_r;
  logic out_v_r;
  logic advance;
  out_t result;

  pvmc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pvmc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_r),
    .cfg    (cfg),
    .result (result)
  );

  // move a beat from input register to result register when there is room
  assign advance   = stage_v_r && (!out_v_r || out_ready);
  assign in_ready  = !stage_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= in_data;
    end
  end

  // result register: load on advance, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/pvmc_checker.sv =====
// ----------------------------------------------------------------------------
// pvmc_checker: port-level checks for the valve motor controller
// Watches handshake and result beats at the top level; bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pvmc_checker
  import pvmc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only when the result side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // band code stays within its range
  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.band != 3'd7)
    else $error("band code out of range");

endmodule

bind pressure_valve_motor_controller pvmc_checker u_pvmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
